### design/psrt_pkg.sv
// Package of shared constants, codes and types for the page swap residency tracker.
package psrt_pkg;

  localparam int NUM_PROCESSES     = 20;
  localparam int PAGES_PER_PROCESS = 20;
  localparam int TRANSFER_TICKS    = 100;
  localparam int PHYSICAL_FRAMES   = 100;

  localparam int ENTRY_W = 8;
  localparam int FREE_W  = 12;
  localparam int LIMIT_W = 7;
  localparam int REM_W   = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd20;
  localparam logic [FREE_W-1:0]  FREE_MAX    = 12'hFFF;

  localparam logic [2:0] CMD_PAGE_IN  = 3'd0;
  localparam logic [2:0] CMD_PAGE_OUT = 3'd1;
  localparam logic [2:0] CMD_TICK     = 3'd2;
  localparam logic [2:0] CMD_LOAD     = 3'd3;
  localparam logic [2:0] CMD_UNLOAD   = 3'd4;
  localparam logic [2:0] CMD_QUERY    = 3'd5;

  localparam logic [1:0] STAT_RESIDENT  = 2'd0;
  localparam logic [1:0] STAT_COMING_IN = 2'd1;
  localparam logic [1:0] STAT_GOING_OUT = 2'd2;
  localparam logic [1:0] STAT_OUT       = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PAGE_IN,
    OP_PAGE_OUT,
    OP_TICK,
    OP_UNLOAD
  } alu_op_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] value;
    logic               write;
    logic               acc;
    logic               take;
    logic               give;
    logic [1:0]         status;
    logic [REM_W-1:0]   remaining;
  } alu_res_t;

  function automatic logic [ENTRY_W-1:0] out_value(input int ticks);
    out_value = ENTRY_W'(-ticks - 1);
  endfunction

endpackage

### design/psrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 400,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/psrt_alu.sv
// Shared page entry update unit: page in, page out, tick aging, unload frame count, status.
module psrt_alu #(
  parameter int TRANSFER_TICKS = psrt_pkg::TRANSFER_TICKS
) (
  input  psrt_pkg::alu_op_t               op,
  input  logic [psrt_pkg::ENTRY_W-1:0]    val,
  input  logic                            frame_avail,
  output psrt_pkg::alu_res_t              res
);

  localparam logic signed [psrt_pkg::ENTRY_W-1:0] TVal = psrt_pkg::ENTRY_W'(TRANSFER_TICKS);
  localparam logic signed [psrt_pkg::ENTRY_W-1:0] NegT = psrt_pkg::ENTRY_W'(-TRANSFER_TICKS);
  localparam logic signed [psrt_pkg::ENTRY_W-1:0] One  = psrt_pkg::ENTRY_W'(1);
  localparam logic signed [psrt_pkg::ENTRY_W-1:0] Zero = '0;

  logic signed [psrt_pkg::ENTRY_W-1:0] v;
  logic signed [psrt_pkg::ENTRY_W-1:0] nv;
  logic signed [psrt_pkg::ENTRY_W-1:0] out_rem;

  always_comb begin
    v = $signed(val);
    nv = v;
    res = '0;
    case (op)
      psrt_pkg::OP_PAGE_IN: begin
        if (v >= Zero) begin
          res.acc = 1'b1;
        end else if (frame_avail && v < NegT) begin
          nv = TVal;
          res.write = 1'b1;
          res.take = 1'b1;
          res.acc = 1'b1;
        end
      end
      psrt_pkg::OP_PAGE_OUT: begin
        if (v < Zero) begin
          res.acc = 1'b1;
        end else if (v == Zero) begin
          nv = -One;
          res.write = 1'b1;
          res.acc = 1'b1;
        end
      end
      psrt_pkg::OP_TICK: begin
        if (v > Zero) begin
          nv = v - One;
          res.write = 1'b1;
        end else if (v < Zero && v >= NegT) begin
          nv = v - One;
          res.write = 1'b1;
          res.give = (v == NegT);
        end
      end
      psrt_pkg::OP_UNLOAD: begin
        res.give = (v >= NegT);
      end
      default: begin
      end
    endcase
    res.value = nv;
    out_rem = nv + TVal + One;
    if (nv > Zero) begin
      res.status = psrt_pkg::STAT_COMING_IN;
      res.remaining = nv[psrt_pkg::REM_W-1:0];
    end else if (nv == Zero) begin
      res.status = psrt_pkg::STAT_RESIDENT;
    end else if (nv >= NegT) begin
      res.status = psrt_pkg::STAT_GOING_OUT;
      res.remaining = out_rem[psrt_pkg::REM_W-1:0];
    end else begin
      res.status = psrt_pkg::STAT_OUT;
    end
  end

endmodule

### design/page_swap_residency_tracker_core.sv
// Page swap residency tracker: one page state RAM, one shared update unit, a sweep sequencer.
//
// One word in, one word out. Page in, page out, query and unused commands read the addressed
// entry, update it and register the result. Load and unload sweep the slot's pages through
// the single RAM port. A tick sweeps every page of slots below the limit in effect, one entry
// a cycle through the same port. Pages of a slot that is not active read as out, so the RAM
// needs no clearing after reset; load rewrites its pages. The input side stalls while a word
// is in work; a finished word waits in the output register.
module page_swap_residency_tracker_core #(
  parameter int NUM_PROCESSES     = psrt_pkg::NUM_PROCESSES,
  parameter int PAGES_PER_PROCESS = psrt_pkg::PAGES_PER_PROCESS,
  parameter int TRANSFER_TICKS    = psrt_pkg::TRANSFER_TICKS,
  parameter int PHYSICAL_FRAMES   = psrt_pkg::PHYSICAL_FRAMES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        limit_write,
  input  logic [6:0]  active_process_limit,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [5:0]  process,
  input  logic [5:0]  page,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [1:0]  page_status,
  output logic [6:0]  remaining,
  output logic [11:0] free_frames
);

  localparam int Depth = NUM_PROCESSES * PAGES_PER_PROCESS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SW    = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int PW    = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
  localparam logic [AW-1:0] PagesA = AW'(PAGES_PER_PROCESS);
  localparam logic [PW-1:0] PageLast = PW'(PAGES_PER_PROCESS - 1);
  localparam logic [psrt_pkg::ENTRY_W-1:0] OutVal = psrt_pkg::out_value(TRANSFER_TICKS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SWEEP = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_RD    = 5'b01000,
    ST_MOD   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [psrt_pkg::LIMIT_W-1:0] limit;
  logic [psrt_pkg::LIMIT_W-1:0] lim;
  logic [NUM_PROCESSES-1:0]     slot_active;
  logic [psrt_pkg::FREE_W-1:0]  free_count;

  logic [2:0]    cmd_q;
  logic [5:0]    proc_q;
  logic [5:0]    page_q;
  logic          valid_q;
  logic          act_q;

  logic [AW-1:0] sw_addr;
  logic [SW-1:0] sw_slot;
  logic [PW-1:0] sw_page;
  logic          sw_last;

  logic          p_valid;
  logic          p_gate;
  logic [AW-1:0] p_addr;

  logic          accept;
  logic          valid_in;
  logic          act_in;
  logic [AW-1:0] base_in;
  logic [AW-1:0] idx;
  logic          commit;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [psrt_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [psrt_pkg::ENTRY_W-1:0]  ram_rdata;

  psrt_pkg::alu_op_t             alu_op;
  logic [psrt_pkg::ENTRY_W-1:0]  alu_val;
  psrt_pkg::alu_res_t            alu_res;
  logic                          acc_word;

  assign lim = (limit < 7'(NUM_PROCESSES)) ? limit : 7'(NUM_PROCESSES);
  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;

  assign valid_in = (7'(process) < lim) && (7'(page) < 7'(PAGES_PER_PROCESS));
  assign act_in = valid_in && slot_active[process[SW-1:0]];
  assign base_in = AW'(process) * PagesA;
  assign idx = AW'(proc_q) * PagesA + AW'(page_q);

  assign sw_last = (sw_page == PageLast) &&
                   ((cmd_q != psrt_pkg::CMD_TICK) || (7'(sw_slot) == lim - 7'd1));

  assign commit = (state == ST_MOD) && (!out_valid || !out_stall);

  always_comb begin
    if (state == ST_MOD) begin
      alu_val = (valid_q && slot_active[proc_q[SW-1:0]]) ? ram_rdata : OutVal;
      if (act_q && cmd_q == psrt_pkg::CMD_PAGE_IN) begin
        alu_op = psrt_pkg::OP_PAGE_IN;
      end else if (act_q && cmd_q == psrt_pkg::CMD_PAGE_OUT) begin
        alu_op = psrt_pkg::OP_PAGE_OUT;
      end else begin
        alu_op = psrt_pkg::OP_NONE;
      end
    end else begin
      alu_val = ram_rdata;
      alu_op = (cmd_q == psrt_pkg::CMD_TICK) ? psrt_pkg::OP_TICK : psrt_pkg::OP_UNLOAD;
    end
  end

  psrt_alu #(
    .TRANSFER_TICKS(TRANSFER_TICKS)
  ) u_alu (
    .op         (alu_op),
    .val        (alu_val),
    .frame_avail(free_count != '0),
    .res        (alu_res)
  );

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx;
    ram_wdata = alu_res.value;
    if (state == ST_SWEEP && cmd_q == psrt_pkg::CMD_LOAD) begin
      ram_we = 1'b1;
      ram_waddr = sw_addr;
      ram_wdata = OutVal;
    end else if (p_valid && p_gate && alu_res.write) begin
      ram_we = 1'b1;
      ram_waddr = p_addr;
    end else if (commit && alu_res.write) begin
      ram_we = 1'b1;
    end
    ram_raddr = (state == ST_SWEEP) ? sw_addr : idx;
  end

  psrt_ram #(
    .WIDTH(psrt_pkg::ENTRY_W),
    .DEPTH(Depth)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    case (cmd_q)
      psrt_pkg::CMD_PAGE_IN:  acc_word = alu_res.acc;
      psrt_pkg::CMD_PAGE_OUT: acc_word = alu_res.acc;
      psrt_pkg::CMD_TICK:     acc_word = 1'b1;
      psrt_pkg::CMD_LOAD:     acc_word = valid_q && !act_q;
      psrt_pkg::CMD_UNLOAD:   acc_word = act_q;
      psrt_pkg::CMD_QUERY:    acc_word = act_q;
      default:                acc_word = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            psrt_pkg::CMD_TICK:   state_next = (lim == '0) ? ST_RD : ST_SWEEP;
            psrt_pkg::CMD_LOAD:   state_next = (valid_in && !act_in) ? ST_SWEEP : ST_RD;
            psrt_pkg::CMD_UNLOAD: state_next = act_in ? ST_SWEEP : ST_RD;
            default:              state_next = ST_RD;
          endcase
        end
      end
      ST_SWEEP: begin
        if (sw_last) begin
          state_next = (cmd_q == psrt_pkg::CMD_LOAD) ? ST_RD : ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_RD;
      ST_RD:    state_next = ST_MOD;
      ST_MOD: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      limit <= psrt_pkg::LIMIT_RESET;
      slot_active <= '0;
      free_count <= psrt_pkg::FREE_W'(PHYSICAL_FRAMES);
      p_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (limit_write) begin
        limit <= active_process_limit;
      end
      p_valid <= (state == ST_SWEEP) && (cmd_q != psrt_pkg::CMD_LOAD);
      if (state == ST_SWEEP && cmd_q == psrt_pkg::CMD_LOAD && sw_last) begin
        slot_active[proc_q[SW-1:0]] <= 1'b1;
      end
      if (state == ST_DRAIN && cmd_q == psrt_pkg::CMD_UNLOAD) begin
        slot_active[proc_q[SW-1:0]] <= 1'b0;
      end
      if (commit && alu_res.take) begin
        free_count <= free_count - 12'd1;
      end else if (p_valid && p_gate && alu_res.give && free_count != psrt_pkg::FREE_MAX) begin
        free_count <= free_count + 12'd1;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      proc_q <= process;
      page_q <= page;
      valid_q <= valid_in;
      act_q <= act_in;
      sw_page <= '0;
      if (command == psrt_pkg::CMD_TICK) begin
        sw_addr <= '0;
        sw_slot <= '0;
      end else begin
        sw_addr <= base_in;
        sw_slot <= process[SW-1:0];
      end
    end else if (state == ST_SWEEP) begin
      sw_addr <= sw_addr + AW'(1);
      if (sw_page == PageLast) begin
        sw_page <= '0;
        sw_slot <= sw_slot + SW'(1);
      end else begin
        sw_page <= sw_page + PW'(1);
      end
    end
    p_addr <= sw_addr;
    p_gate <= (cmd_q == psrt_pkg::CMD_UNLOAD) || slot_active[sw_slot];
    if (commit) begin
      accepted <= acc_word;
      page_status <= valid_q ? alu_res.status : psrt_pkg::STAT_RESIDENT;
      remaining <= valid_q ? alu_res.remaining : '0;
      free_frames <= alu_res.take ? free_count - 12'd1 : free_count;
    end
  end

  a_pipe_in_sweep: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == ST_SWEEP || state == ST_DRAIN))
    else $error("sweep pipeline active outside a sweep");

  a_out_from_mod: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_MOD))
    else $error("result word raised without an update step");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state != ST_IDLE && state != ST_RD))
    else $error("page state written while no word is in work");

endmodule

### verif/page_swap_residency_tracker_checker.sv
// Checker for the page swap residency tracker: predicts each reply word and compares it.
`timescale 1ns / 1ps

module page_swap_residency_tracker_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        limit_write,
  input  logic [6:0]  active_process_limit,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  command,
  input  logic [5:0]  slot,
  input  logic [5:0]  page,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        accepted,
  input  logic [1:0]  page_status,
  input  logic [6:0]  remaining,
  input  logic [11:0] free_frames,
  output int          pending,
  output int          errors
);

  localparam int PAGE_COUNT = psrt_pkg::NUM_PROCESSES * psrt_pkg::PAGES_PER_PROCESS;
  localparam logic signed [psrt_pkg::ENTRY_W-1:0] OUT_STATE =
    psrt_pkg::ENTRY_W'(-psrt_pkg::TRANSFER_TICKS - 1);

  typedef struct packed {
    logic                        acc;
    logic [1:0]                  status;
    logic [psrt_pkg::REM_W-1:0]  rem;
    logic [psrt_pkg::FREE_W-1:0] frames;
  } reply_t;

  logic signed [psrt_pkg::ENTRY_W-1:0] page_timer [PAGE_COUNT];
  logic                                slot_loaded [psrt_pkg::NUM_PROCESSES];
  logic [psrt_pkg::FREE_W-1:0]         frames_free;
  logic [psrt_pkg::LIMIT_W-1:0]        limit_reg;
  reply_t                              expected_replies [$];

  function automatic void clear_tracking();
    for (int i = 0; i < PAGE_COUNT; i++) page_timer[i] = OUT_STATE;
    for (int s = 0; s < psrt_pkg::NUM_PROCESSES; s++) slot_loaded[s] = 1'b0;
    frames_free = psrt_pkg::FREE_W'(psrt_pkg::PHYSICAL_FRAMES);
    limit_reg   = psrt_pkg::LIMIT_RESET;
  endfunction

  function automatic void return_frame();
    if (frames_free != psrt_pkg::FREE_MAX) frames_free++;
  endfunction

  function automatic reply_t track_request(input logic [2:0] cmd, input logic [5:0] s,
                                           input logic [5:0] pg);
    int     lim;
    int     idx;
    int     v;
    bit     ok;
    bit     act;
    reply_t r;
    lim = (limit_reg < psrt_pkg::NUM_PROCESSES) ? int'(limit_reg) : psrt_pkg::NUM_PROCESSES;
    ok  = (s < lim) && (pg < psrt_pkg::PAGES_PER_PROCESS);
    act = ok && slot_loaded[s];
    idx = ok ? s * psrt_pkg::PAGES_PER_PROCESS + pg : 0;
    r   = '0;
    case (cmd)
      psrt_pkg::CMD_PAGE_IN: begin
        if (act) begin
          v = page_timer[idx];
          if (v >= 0) begin
            r.acc = 1'b1;
          end else if (frames_free != 0 && v < -psrt_pkg::TRANSFER_TICKS) begin
            page_timer[idx] = psrt_pkg::ENTRY_W'(psrt_pkg::TRANSFER_TICKS);
            frames_free--;
            r.acc = 1'b1;
          end
        end
      end
      psrt_pkg::CMD_PAGE_OUT: begin
        if (act) begin
          v = page_timer[idx];
          if (v < 0) begin
            r.acc = 1'b1;
          end else if (v == 0) begin
            page_timer[idx] = -1;
            r.acc = 1'b1;
          end
        end
      end
      psrt_pkg::CMD_TICK: begin
        for (int i = 0; i < lim; i++) begin
          if (slot_loaded[i]) begin
            for (int j = 0; j < psrt_pkg::PAGES_PER_PROCESS; j++) begin
              v = page_timer[i * psrt_pkg::PAGES_PER_PROCESS + j];
              if (v > 0) begin
                page_timer[i * psrt_pkg::PAGES_PER_PROCESS + j] = psrt_pkg::ENTRY_W'(v - 1);
              end else if (v < 0 && v >= -psrt_pkg::TRANSFER_TICKS) begin
                page_timer[i * psrt_pkg::PAGES_PER_PROCESS + j] = psrt_pkg::ENTRY_W'(v - 1);
                if (v - 1 < -psrt_pkg::TRANSFER_TICKS) return_frame();
              end
            end
          end
        end
        r.acc = 1'b1;
      end
      psrt_pkg::CMD_LOAD: begin
        if (ok && !slot_loaded[s]) begin
          for (int j = 0; j < psrt_pkg::PAGES_PER_PROCESS; j++)
            page_timer[s * psrt_pkg::PAGES_PER_PROCESS + j] = OUT_STATE;
          slot_loaded[s] = 1'b1;
          r.acc = 1'b1;
        end
      end
      psrt_pkg::CMD_UNLOAD: begin
        if (act) begin
          for (int j = 0; j < psrt_pkg::PAGES_PER_PROCESS; j++) begin
            if (page_timer[s * psrt_pkg::PAGES_PER_PROCESS + j] >= -psrt_pkg::TRANSFER_TICKS)
            begin
              return_frame();
              page_timer[s * psrt_pkg::PAGES_PER_PROCESS + j] = OUT_STATE;
            end
          end
          slot_loaded[s] = 1'b0;
          r.acc = 1'b1;
        end
      end
      psrt_pkg::CMD_QUERY: r.acc = act;
      default: ;
    endcase
    if (ok) begin
      v = page_timer[idx];
      if (v > 0) begin
        r.status = psrt_pkg::STAT_COMING_IN;
        r.rem    = psrt_pkg::REM_W'(v);
      end else if (v == 0) begin
        r.status = psrt_pkg::STAT_RESIDENT;
      end else if (v >= -psrt_pkg::TRANSFER_TICKS) begin
        r.status = psrt_pkg::STAT_GOING_OUT;
        r.rem    = psrt_pkg::REM_W'(v + psrt_pkg::TRANSFER_TICKS + 1);
      end else begin
        r.status = psrt_pkg::STAT_OUT;
      end
    end
    r.frames = frames_free;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [11:0] want_v,
                                      input logic [11:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      clear_tracking();
      expected_replies.delete();
    end else begin
      if (limit_write) limit_reg = active_process_limit;
      if (in_valid && !in_stall)
        expected_replies.push_back(track_request(command, slot, page));
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $error("reply word with no request waiting");
          errors++;
        end else begin
          want = expected_replies.pop_front();
          check_field("accepted", 12'(want.acc), 12'(accepted));
          check_field("page_status", 12'(want.status), 12'(page_status));
          check_field("remaining", 12'(want.rem), 12'(remaining));
          check_field("free_frames", want.frames, free_frames);
        end
      end
    end
    pending = expected_replies.size();
  end

endmodule

### verif/page_swap_residency_tracker_core_tb.sv
// Testbench top for the page swap residency tracker: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module page_swap_residency_tracker_core_tb;

  typedef enum {QUIET, SEND_GAPS, RECV_STALLS, BOTH_GAPS} pace_t;

  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        limit_write = 1'b0;
  logic [6:0]  active_process_limit = psrt_pkg::LIMIT_RESET;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  command = psrt_pkg::CMD_QUERY;
  logic [5:0]  slot = '0;
  logic [5:0]  page = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        accepted;
  logic [1:0]  page_status;
  logic [6:0]  remaining;
  logic [11:0] free_frames;
  int          pending;
  int          errors;

  pace_t pace = QUIET;
  int    cur_limit = psrt_pkg::LIMIT_RESET;
  logic  hold_req = 1'b0;
  logic  hold_seen = 1'b0;
  int    hold_left = 0;

  page_swap_residency_tracker_core uut (
    .clk(clk), .rst(rst),
    .limit_write(limit_write), .active_process_limit(active_process_limit),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .process(slot), .page(page),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .page_status(page_status),
    .remaining(remaining), .free_frames(free_frames)
  );

  page_swap_residency_tracker_checker u_checker (
    .clk(clk), .rst(rst),
    .limit_write(limit_write), .active_process_limit(active_process_limit),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .slot(slot), .page(page),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .page_status(page_status),
    .remaining(remaining), .free_frames(free_frames),
    .pending(pending), .errors(errors)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_seen = hold_req;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= roll(pace == RECV_STALLS ? 88 : pace == BOTH_GAPS ? 20 : 0);
    end
  end

  task automatic send_word(input logic [2:0] c, input logic [5:0] s, input logic [5:0] g);
    while (roll(pace == SEND_GAPS ? 88 : pace == BOTH_GAPS ? 20 : 0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= c;
    slot     <= s;
    page     <= g;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_limit(input logic [6:0] v);
    settle();
    limit_write          <= 1'b1;
    active_process_limit <= v;
    @(posedge clk);
    limit_write <= 1'b0;
    cur_limit = v;
  endtask

  task automatic run_phase(input pace_t p, input int n, input int tick_pct, input int pin_pct);
    int         eff;
    int         r;
    logic [2:0] c;
    logic [5:0] s;
    logic [5:0] g;
    pace = p;
    eff = (cur_limit < psrt_pkg::NUM_PROCESSES) ? cur_limit : psrt_pkg::NUM_PROCESSES;
    for (int k = 0; k < n; k++) begin
      s = 6'($urandom_range(0, eff - 1));
      g = 6'($urandom_range(0, psrt_pkg::PAGES_PER_PROCESS - 1));
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        c = psrt_pkg::CMD_TICK;
      end else if (r < tick_pct + pin_pct) begin
        c = psrt_pkg::CMD_PAGE_IN;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) c = psrt_pkg::CMD_PAGE_OUT;
        else if (r < 65) c = psrt_pkg::CMD_QUERY;
        else if (r < 80) c = psrt_pkg::CMD_LOAD;
        else if (r < 83) c = psrt_pkg::CMD_UNLOAD;
        else begin
          c = 3'($urandom_range(0, 7));
          s = 6'($urandom_range(0, 63));
          g = 6'($urandom_range(0, 63));
        end
      end
      send_word(c, s, g);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(psrt_pkg::CMD_QUERY, 0, 0);
    send_word(psrt_pkg::CMD_PAGE_IN, 0, 0);
    send_word(psrt_pkg::CMD_UNLOAD, 0, 0);
    send_word(psrt_pkg::CMD_LOAD, 0, 0);
    send_word(psrt_pkg::CMD_LOAD, 0, 5);
    send_word(psrt_pkg::CMD_LOAD, 19, 19);
    send_word(psrt_pkg::CMD_QUERY, 19, 19);
    send_word(psrt_pkg::CMD_PAGE_IN, 0, 0);
    send_word(psrt_pkg::CMD_PAGE_IN, 0, 0);
    send_word(psrt_pkg::CMD_PAGE_OUT, 0, 0);
    send_word(psrt_pkg::CMD_PAGE_IN, 19, 19);
    send_word(psrt_pkg::CMD_TICK, 0, 0);
    send_word(psrt_pkg::CMD_QUERY, 20, 0);
    send_word(psrt_pkg::CMD_PAGE_IN, 63, 63);
    send_word(psrt_pkg::CMD_QUERY, 0, 20);
    send_word(3'd6, 0, 0);
    send_word(3'd7, 63, 63);
    send_word(psrt_pkg::CMD_PAGE_OUT, 0, 1);
    send_word(psrt_pkg::CMD_UNLOAD, 19, 0);
    send_word(psrt_pkg::CMD_TICK, 63, 63);
    send_word(psrt_pkg::CMD_LOAD, 63, 0);
    send_word(psrt_pkg::CMD_QUERY, 0, 0);

    set_limit(1);
    run_phase(QUIET, 250, 45, 20);
    set_limit(3);
    run_phase(SEND_GAPS, 250, 45, 20);
    set_limit(64);
    run_phase(RECV_STALLS, 200, 15, 25);

    // load every slot, then page in hard enough to run out of frames
    set_limit(20);
    pace = QUIET;
    hold_req <= ~hold_req;
    for (int s = 0; s < psrt_pkg::NUM_PROCESSES; s++) send_word(psrt_pkg::CMD_LOAD, 6'(s), 0);
    run_phase(QUIET, 230, 5, 60);

    set_limit(6);
    run_phase(BOTH_GAPS, 300, 45, 20);
    set_limit(2);
    run_phase(QUIET, 250, 50, 15);

    settle();
    repeat (420) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
